// File: rtl/utf8_stream_validator_unit_macros.svh
// Assertion macros for the UTF-8 stream validator checker.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define U8SV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sv assertion failed");

// Next-cycle implication, checked only out of reset.
`define U8SV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sv assertion failed");

// Next-cycle implication, checked during reset as well.
`define U8SV_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("u8sv assertion failed");

`endif

// File: rtl/u8sv_pkg.sv
// Types and constants for the UTF-8 stream validator.
package u8sv_pkg;

    localparam int BYTE_W = 8;

    // Lead and continuation byte masks and patterns
    localparam logic [BYTE_W-1:0] MASK_1 = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_CONT = 8'h80;
    localparam logic [BYTE_W-1:0] PAT_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] MIN_AFTER_E0 = 8'hA0;
    localparam logic [BYTE_W-1:0] MIN_AFTER_F0 = 8'h90;

    typedef enum logic [1:0] {
        MIN_NONE = 2'd0,
        MIN_A0   = 2'd1,
        MIN_90   = 2'd2
    } t_min;

    typedef struct packed {
        logic [1:0] pending;
        t_min       first_min;
        logic       failed;
    } t_state;

    // Result of one step, handed to the output register
    typedef struct packed {
        logic ok;
        logic final_res;
    } t_result;

endpackage

// File: rtl/utf8_stream_validator_unit.sv
// Top level of the UTF-8 stream validator.
// Checks UTF-8 well-formedness of a byte string, one byte per beat, and
// returns exactly one result beat per input beat. Input beat: tdata is the
// byte, tlast marks the final beat of the string, tuser set means the beat
// carries no byte (a lone tuser+tlast beat closes an empty string, which is
// valid). Output beat: tdata[0] is ok-so-far (on the tlast beat, the verdict
// for the whole string) and tlast marks that verdict beat. A violation is
// sticky until the string ends; a sequence still open at the final beat
// fails. Leads F5..F7, C0/C1 and surrogates are let through. Throughput is
// one beat per clock while the downstream takes results; output valid rises
// once the beat has passed the input register and been decoded into the
// result register. The sequence state is updated in one step per byte.
// Input tready falls only when the input register is full and the result
// register is held by a stalled downstream.
module utf8_stream_validator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [u8sv_pkg::BYTE_W-1:0]  i_s_axis_tdata,  // [7:0] byte_value
    input  logic                         i_s_axis_tlast,  // is_last
    input  logic                         i_s_axis_tuser,  // [0] no_byte
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,  // [0] ok_so_far, [7:1] zero
    output logic                         o_m_axis_tlast   // final_res
);
    import u8sv_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_in_none;

    // Result register
    logic              r_out_valid;
    t_result           r_out;

    logic              s_advance;
    logic              s_accept;
    t_result           s_result;

    // Move the held beat into the result slot when the slot is free or draining
    assign s_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || s_advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    u8sv_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s_advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_none    (r_in_none),
        .o_result  (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
            r_in_none <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_out <= s_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.ok};
    assign o_m_axis_tlast  = r_out.final_res;

endmodule

// File: rtl/u8sv_step.sv
// Decoder and state register: one byte per advance.
module u8sv_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [u8sv_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_last,
    input  logic                         i_none,
    output u8sv_pkg::t_result            o_result
);
    import u8sv_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state s_after;

    always_comb begin
        s_after = r_state;
        if (!i_none && !r_state.failed) begin
            if (r_state.pending != 2'd0) begin
                if ((i_byte & MASK_CONT) != PAT_CONT) begin
                    s_after.failed = 1'b1;
                end else if (r_state.first_min == MIN_A0 && i_byte < MIN_AFTER_E0) begin
                    s_after.failed = 1'b1;
                end else if (r_state.first_min == MIN_90 && i_byte < MIN_AFTER_F0) begin
                    s_after.failed = 1'b1;
                end
                s_after.first_min = MIN_NONE;
                s_after.pending   = r_state.pending - 2'd1;
            end else if ((i_byte & MASK_1) == 8'h00) begin
                s_after = r_state;
            end else if ((i_byte & MASK_2) == PAT_LEAD2) begin
                s_after.pending   = 2'd1;
                s_after.first_min = MIN_NONE;
            end else if ((i_byte & MASK_3) == PAT_LEAD3) begin
                s_after.pending   = 2'd2;
                s_after.first_min = (i_byte == PAT_LEAD3) ? MIN_A0 : MIN_NONE;
            end else if ((i_byte & MASK_4) == PAT_LEAD4) begin
                s_after.pending   = 2'd3;
                s_after.first_min = (i_byte == PAT_LEAD4) ? MIN_90 : MIN_NONE;
            end else begin
                s_after.failed = 1'b1;
            end
        end

        if (i_last) begin
            o_result.ok        = !s_after.failed && (s_after.pending == 2'd0);
            o_result.final_res = 1'b1;
            n_state            = '{pending: 2'd0, first_min: MIN_NONE, failed: 1'b0};
        end else begin
            o_result.ok        = !s_after.failed;
            o_result.final_res = 1'b0;
            n_state            = s_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pending: 2'd0, first_min: MIN_NONE, failed: 1'b0};
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/u8sv_checker.sv
// Port-level checker for the UTF-8 stream validator, with its bind.
module u8sv_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    input  logic                         o_s_axis_tready,
    input  logic [u8sv_pkg::BYTE_W-1:0]  i_s_axis_tdata,
    input  logic                         i_s_axis_tlast,
    input  logic                         i_s_axis_tuser,
    input  logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  logic [7:0]                   o_m_axis_tdata,
    input  logic                         o_m_axis_tlast
);
    `include "utf8_stream_validator_unit_macros.svh"

    logic r_seen_fail;
    logic s_out_beat;
    logic s_in_beat_unused;

    assign s_out_beat       = o_m_axis_tvalid && i_m_axis_tready;
    assign s_in_beat_unused = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast
                              && i_s_axis_tuser && (i_s_axis_tdata != 8'h00);

    // Tracks a failure reported earlier in the current string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fail <= 1'b0;
        end else if (s_out_beat) begin
            r_seen_fail <= !o_m_axis_tlast && !o_m_axis_tdata[0];
        end
    end

    `U8SV_ASSERT_NXT_ALWAYS(a_rst_no_valid, i_clk, !i_rst_n, !o_m_axis_tvalid)
    `U8SV_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `U8SV_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid || s_in_beat_unused, o_m_axis_tdata[7:1] == 7'd0)
    `U8SV_ASSERT_IMP(a_fail_sticky, i_clk, i_rst_n, o_m_axis_tvalid && r_seen_fail, !o_m_axis_tdata[0])

endmodule

bind utf8_stream_validator_unit u8sv_checker u_u8sv_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the UTF-8 stream validator.

typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       nb;     // beat carries no byte
} t_utf8_beat;

// Tracks the validation state of the string in flight and queues the verdict
// each input beat must produce.
class utf8_verdict_board;
    logic [1:0]           cont_left;
    u8sv_pkg::t_min       cont_floor;
    logic                 broken;
    u8sv_pkg::t_result    verdicts_due[$];
    int unsigned          mismatches;

    function new();
        clear_string();
        mismatches = 0;
    endfunction

    function void clear_string();
        cont_left  = 2'd0;
        cont_floor = u8sv_pkg::MIN_NONE;
        broken     = 1'b0;
    endfunction

    // Input beat accepted: advance the decoder and queue its verdict.
    function void take_beat(logic [7:0] b, logic last, logic nb);
        u8sv_pkg::t_result r;
        // once broken, bytes are skipped until the string closes
        if (!nb && !broken) begin
            if (cont_left != 2'd0) begin
                if ((b & u8sv_pkg::MASK_CONT) != u8sv_pkg::PAT_CONT)
                    broken = 1'b1;
                else if (cont_floor == u8sv_pkg::MIN_A0 && b < u8sv_pkg::MIN_AFTER_E0)
                    broken = 1'b1;
                else if (cont_floor == u8sv_pkg::MIN_90 && b < u8sv_pkg::MIN_AFTER_F0)
                    broken = 1'b1;
                cont_floor = u8sv_pkg::MIN_NONE;
                cont_left  = cont_left - 2'd1;
            end else if ((b & u8sv_pkg::MASK_1) == 8'h00) begin
                // plain ASCII
            end else if ((b & u8sv_pkg::MASK_2) == u8sv_pkg::PAT_LEAD2) begin
                cont_left  = 2'd1;
                cont_floor = u8sv_pkg::MIN_NONE;
            end else if ((b & u8sv_pkg::MASK_3) == u8sv_pkg::PAT_LEAD3) begin
                cont_left  = 2'd2;
                cont_floor = (b == u8sv_pkg::PAT_LEAD3) ? u8sv_pkg::MIN_A0
                                                        : u8sv_pkg::MIN_NONE;
            end else if ((b & u8sv_pkg::MASK_4) == u8sv_pkg::PAT_LEAD4) begin
                cont_left  = 2'd3;
                cont_floor = (b == u8sv_pkg::PAT_LEAD4) ? u8sv_pkg::MIN_90
                                                        : u8sv_pkg::MIN_NONE;
            end else begin
                // stray continuation or 11111xxx
                broken = 1'b1;
            end
        end
        if (last) begin
            r.ok        = !broken && (cont_left == 2'd0);
            r.final_res = 1'b1;
            clear_string();
        end else begin
            r.ok        = !broken;
            r.final_res = 1'b0;
        end
        verdicts_due.insert(verdicts_due.size(), r);
    endfunction

    // Output beat accepted: compare with the oldest queued verdict.
    function void check_result(logic [7:0] data, logic last);
        u8sv_pkg::t_result want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: result beat with nothing queued: tdata=%h tlast=%b",
                     $time, data, last);
            mismatches++;
            return;
        end
        want = verdicts_due.pop_front();
        if (data[0] !== want.ok) begin
            $display("%0t: ok_so_far expected %0b got %0b", $time, want.ok, data[0]);
            mismatches++;
        end
        if (last !== want.final_res) begin
            $display("%0t: final_res expected %0b got %0b", $time, want.final_res, last);
            mismatches++;
        end
        if (data[7:1] !== 7'd0) begin
            $display("%0t: tdata pad expected 00 got %h", $time, data[7:1]);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_BEATS = 800;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] byte_value
    logic       i_s_axis_tlast;   // is_last
    logic       i_s_axis_tuser;   // [0] no_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [0] ok_so_far, [7:1] zero
    logic       o_m_axis_tlast;   // final_res

    utf8_verdict_board board;
    int unsigned       src_idle_pct;
    int unsigned       sink_stall_pct;
    int unsigned       beats_sent;

    utf8_stream_validator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAIL utf8_stream_validator_unit");
        $finish;
    end

    // Result side: check on each accepted beat, then pick the next ready.
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata, o_m_axis_tlast);
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offers one beat, with random idle cycles ahead of it, and returns on
    // the edge at which it is taken.
    task automatic send_beat(input t_utf8_beat bt);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= bt.val;
        i_s_axis_tlast  <= bt.last;
        i_s_axis_tuser  <= bt.nb;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        board.take_beat(bt.val, bt.last, bt.nb);
        beats_sent++;
    endtask

    // Sends a byte string, tlast on the final byte.
    task automatic send_text(input logic [7:0] txt[$]);
        t_utf8_beat bt;
        foreach (txt[i]) begin
            bt.val  = txt[i];
            bt.last = (i == txt.size() - 1);
            bt.nb   = 1'b0;
            send_beat(bt);
        end
    endtask

    // Holds the sender off until every queued verdict has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (board.verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One random string: mostly well-formed code points, some corrupted,
    // truncated or pure noise, with the odd empty beat mixed in.
    task automatic compose_text(output t_utf8_beat beats[$]);
        logic [7:0]  raw[$];
        logic [7:0]  lead;
        logic [7:0]  tricky[12];
        t_utf8_beat  bt;
        int unsigned chars;
        int unsigned n;
        tricky = '{8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0,
                   8'hBF, 8'hC0, 8'hE0, 8'hF0, 8'hF7, 8'hF8};
        raw.delete();
        beats.delete();
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(8, 1);
            repeat (n) raw.insert(raw.size(), 8'($urandom_range(255, 0)));
        end else begin
            chars = $urandom_range(6, 0);
            repeat (chars) begin
                case ($urandom_range(4, 1))
                    1: begin
                        raw.insert(raw.size(), 8'($urandom_range(8'h7F, 8'h00)));
                    end
                    2: begin
                        raw.insert(raw.size(), 8'($urandom_range(8'hDF, 8'hC0)));
                        raw.insert(raw.size(), 8'($urandom_range(8'hBF, 8'h80)));
                    end
                    3: begin
                        // bias towards E0 so its tighter floor is hit often
                        lead = ($urandom_range(3) == 0) ? 8'hE0
                                                        : 8'($urandom_range(8'hEF, 8'hE0));
                        raw.insert(raw.size(), lead);
                        raw.insert(raw.size(),
                                   (lead == 8'hE0) ? 8'($urandom_range(8'hBF, 8'hA0))
                                                   : 8'($urandom_range(8'hBF, 8'h80)));
                        raw.insert(raw.size(), 8'($urandom_range(8'hBF, 8'h80)));
                    end
                    default: begin
                        lead = ($urandom_range(3) == 0) ? 8'hF0
                                                        : 8'($urandom_range(8'hF7, 8'hF0));
                        raw.insert(raw.size(), lead);
                        raw.insert(raw.size(),
                                   (lead == 8'hF0) ? 8'($urandom_range(8'hBF, 8'h90))
                                                   : 8'($urandom_range(8'hBF, 8'h80)));
                        raw.insert(raw.size(), 8'($urandom_range(8'hBF, 8'h80)));
                        raw.insert(raw.size(), 8'($urandom_range(8'hBF, 8'h80)));
                    end
                endcase
            end
            if (raw.size() != 0 && $urandom_range(99) < 25) begin
                case ($urandom_range(2))
                    0: raw[$urandom_range(raw.size() - 1)] = 8'($urandom_range(255, 0));
                    1: void'(raw.pop_back());
                    default: raw[$urandom_range(raw.size() - 1)] = tricky[$urandom_range(11)];
                endcase
            end
        end
        foreach (raw[i]) begin
            if ($urandom_range(99) < 5) begin
                bt.val  = 8'($urandom_range(255, 0));
                bt.last = 1'b0;
                bt.nb   = 1'b1;
                beats.insert(beats.size(), bt);
            end
            bt.val  = raw[i];
            bt.last = 1'b0;
            bt.nb   = 1'b0;
            beats.insert(beats.size(), bt);
        end
        // close with a byteless beat when empty, otherwise now and then
        if (beats.size() == 0 || $urandom_range(99) < 15) begin
            bt.val  = 8'($urandom_range(255, 0));
            bt.last = 1'b1;
            bt.nb   = 1'b1;
            beats.insert(beats.size(), bt);
        end else begin
            beats[beats.size() - 1].last = 1'b1;
        end
    endtask

    initial begin
        t_utf8_beat  bt;
        t_utf8_beat  beats[$];
        logic [7:0]  txt[$];
        int unsigned phase_end;

        board          = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        beats_sent     = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings, back to back.
        // empty string: a lone byteless last beat
        bt = '{val: 8'hFF, last: 1'b1, nb: 1'b1};
        send_beat(bt);
        // valid mix: NUL, 2-byte, E0 at its floor, F0 at its floor
        txt = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF,
                8'hF0, 8'h90, 8'h80, 8'h80};
        send_text(txt);
        // E0 followed by 9F: below the floor
        txt = '{8'hE0, 8'h9F};
        send_text(txt);
        // F0 followed by 8F: below the floor
        txt = '{8'hF0, 8'h8F};
        send_text(txt);
        // byteless beat mid-string, then a sequence cut short at the end
        txt = '{8'hE1};
        foreach (txt[i]) begin
            bt = '{val: txt[i], last: 1'b0, nb: 1'b0};
            send_beat(bt);
        end
        bt = '{val: 8'h00, last: 1'b0, nb: 1'b1};
        send_beat(bt);
        bt = '{val: 8'h80, last: 1'b1, nb: 1'b0};
        send_beat(bt);
        // stray continuation, then a byte that must be skipped
        txt = '{8'h80, 8'hFF};
        send_text(txt);
        // overlong C1, surrogate, F5 lead: all let through
        txt = '{8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'hBF};
        send_text(txt);
        drain_results();

        // Random strings over four idling phases; each phase ends with the
        // sender holding off until the pipe is empty.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            phase_end = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < phase_end) begin
                compose_text(beats);
                foreach (beats[i])
                    send_beat(beats[i]);
            end
            drain_results();
        end

        // Let any stray extra beat surface before the verdict.
        sink_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
            $display("PASS utf8_stream_validator_unit");
        end else begin
            $display("FAIL utf8_stream_validator_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/u8sv_pkg.sv
rtl/u8sv_step.sv
rtl/utf8_stream_validator_unit.sv
rtl/u8sv_checker.sv
tb/tb_top.sv
